### src/fpr_pkg.sv
// Shared types and constants of the framed packet receiver.
// Used by fpr_front, fpr_queue, fpr_back and framed_packet_receiver; no dependencies.
package fpr_pkg;

	localparam logic [7:0] START_RESET = 8'h02;
	localparam logic [7:0] STOP_RESET  = 8'h03;

	// Bytes of a frame besides its payload: start, length, type, checksum, stop.
	localparam int FRAME_OVERHEAD = 5;
	// Position of the first payload byte within a frame.
	localparam int PAYLOAD_OFS    = 3;

	typedef enum logic {
		CFG_START = 1'b0,
		CFG_STOP  = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_LONG     = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_CHECKSUM = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	// One finished frame as handed from the front to the back.
	typedef struct packed {
		status_t     status;
		logic [7:0]  frame_type;
		logic [5:0]  payload_length;
		logic        bank;
	} desc_t;

	typedef enum logic {
		B_IDLE = 1'b0,
		B_SEND = 1'b1
	} back_state_t;

endpackage

### src/fpr_front.sv
// Receive front end: holds the framing bytes, tracks the frame and validates it on stop.
// Depends on fpr_pkg; writes payload bytes into the buffer held by fpr_back.
module fpr_front import fpr_pkg::*; #(
	parameter int MAX_PAYLOAD = 32,
	parameter int AW          = 5,
	parameter int CW          = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          q_full,
	output logic          push,
	output desc_t         push_desc,
	output logic          pay_we,
	output logic          pay_wbank,
	output logic [AW-1:0] pay_waddr,
	output logic [7:0]    pay_wdata
);

	logic [7:0]    start_q, stop_q;
	logic          in_frame_q;
	logic [CW-1:0] count_q;
	logic          wr_bank_q;
	logic [7:0]    len_q, type_q, xor_q;

	logic          take, overflow, is_stop;
	logic [CW-1:0] pos, count_next;
	logic [7:0]    cur_xor;
	status_t       status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			stop_q  <= STOP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_START: start_q <= cfg_data;
				CFG_STOP:  stop_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready   = !q_full;
	assign take       = s_tvalid && s_tready && (in_frame_q || s_tdata == start_q);
	assign pos        = in_frame_q ? count_q : '0;
	assign cur_xor    = in_frame_q ? xor_q : 8'd0;
	assign overflow   = in_frame_q && (count_q >= CW'(MAX_PAYLOAD + FRAME_OVERHEAD));
	assign is_stop    = s_tdata == stop_q;
	assign count_next = pos + CW'(1);
	assign push       = take && (overflow || is_stop);

	always_comb begin
		if (overflow) begin
			status = ST_OVERFLOW;
		end else if (count_next < CW'(FRAME_OVERHEAD)) begin
			status = ST_SHORT;
		end else if (len_q > 8'(MAX_PAYLOAD)) begin
			status = ST_LONG;
		end else if (count_next != CW'({1'b0, len_q} + 9'(FRAME_OVERHEAD))) begin
			status = ST_MISMATCH;
		end else if (cur_xor != 8'd0) begin
			status = ST_CHECKSUM;
		end else begin
			status = ST_OK;
		end
	end

	assign push_desc.status         = status;
	assign push_desc.frame_type     = type_q;
	assign push_desc.payload_length = len_q[5:0];
	assign push_desc.bank           = wr_bank_q;

	assign pay_we    = take && !overflow && (pos >= CW'(PAYLOAD_OFS))
		&& (pos < CW'(MAX_PAYLOAD + PAYLOAD_OFS));
	assign pay_wbank = wr_bank_q;
	assign pay_waddr = AW'(pos - CW'(PAYLOAD_OFS));
	assign pay_wdata = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			wr_bank_q  <= 1'b0;
		end else begin
			if (take) begin
				if (push) begin
					in_frame_q <= 1'b0;
					count_q    <= '0;
				end else begin
					in_frame_q <= 1'b1;
					count_q    <= count_next;
				end
			end
			if (push) begin
				wr_bank_q <= !wr_bank_q;
			end
		end
	end

	// The running checksum covers every stored byte after the start byte.
	always_ff @(posedge clk) begin
		if (take && !overflow) begin
			if (pos == CW'(1)) begin
				len_q <= s_tdata;
			end
			if (pos == CW'(2)) begin
				type_q <= s_tdata;
			end
			if (pos == '0) begin
				xor_q <= 8'd0;
			end else begin
				xor_q <= cur_xor ^ s_tdata;
			end
		end
	end

endmodule

### src/fpr_queue.sv
// Two-entry queue of frame descriptors between the front and the back.
// Depends on fpr_pkg for the descriptor type.
module fpr_queue import fpr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output desc_t head
);

	desc_t      entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

### src/fpr_back.sv
// Result back end: two payload banks and the beat sequencer that drains one frame at a time.
// Depends on fpr_pkg; reads descriptors from fpr_queue and payload written by fpr_front.
module fpr_back import fpr_pkg::*; #(
	parameter int MAX_PAYLOAD = 32,
	parameter int AW          = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pay_we,
	input  logic          pay_wbank,
	input  logic [AW-1:0] pay_waddr,
	input  logic [7:0]    pay_wdata,
	input  logic          q_empty,
	input  desc_t         head,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic          m_tlast,
	output logic [2:0]    m_tuser
);

	localparam int DEPTH = 2 * MAX_PAYLOAD;
	localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]    mem_q [DEPTH];
	logic [7:0]    rdata_q;
	back_state_t   state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [MW-1:0] widx, ridx;

	logic          is_ok, has_pay, last_beat, fire;
	logic [7:0]    frame_type, payload_byte;
	logic [5:0]    payload_length;
	logic [4:0]    payload_index;

	assign widx = pay_wbank ? MW'(MAX_PAYLOAD) + MW'(pay_waddr) : MW'(pay_waddr);
	assign ridx = head.bank ? MW'(MAX_PAYLOAD) + MW'(idx_d) : MW'(idx_d);

	always_ff @(posedge clk) begin
		if (pay_we) begin
			mem_q[widx] <= pay_wdata;
		end
		rdata_q <= mem_q[ridx];
	end

	assign is_ok     = head.status == ST_OK;
	assign has_pay   = is_ok && (head.payload_length != 6'd0);
	assign last_beat = !has_pay || (6'(idx_q) + 6'd1 == head.payload_length);
	assign m_tvalid  = state_q == B_SEND;
	assign fire      = m_tvalid && m_tready;
	assign pop       = fire && last_beat;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					state_d = B_SEND;
				end
			end
			B_SEND: begin
				if (fire) begin
					if (last_beat) begin
						state_d = B_IDLE;
						idx_d   = '0;
					end else begin
						idx_d = idx_q + AW'(1);
					end
				end
			end
			default: begin
				state_d = B_IDLE;
				idx_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign frame_type     = is_ok ? head.frame_type : 8'd0;
	assign payload_length = has_pay ? head.payload_length : 6'd0;
	assign payload_index  = has_pay ? 5'(idx_q) : 5'd0;
	assign payload_byte   = has_pay ? rdata_q : 8'd0;

	assign m_tdata = {5'd0, payload_byte, payload_index, payload_length, frame_type};
	assign m_tlast = last_beat;
	assign m_tuser = head.status;

endmodule

### src/framed_packet_receiver.sv
// Top level of the framed packet receiver: byte stream in, payload beats out.
// Depends on fpr_pkg, fpr_front, fpr_queue and fpr_back.
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   s_tdata: received byte
//   m_*       out        m_tvalid / m_tready   m_tdata, m_tlast, m_tuser: status
//   cfg_*     in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// The front takes one byte per cycle as long as fewer than two finished frames wait.
// One beat goes out per cycle while m_tready is high; B_IDLE reads the first payload byte.
// s_tready drops only while two finished frames wait to be sent.
// Reset clears control state, presets start/stop; the payload buffer holds no reset value.
module framed_packet_receiver import fpr_pkg::*; #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] frame_type, [13:8] payload_length,
	                               // [18:14] payload_index, [26:19] payload_byte
	output logic        m_tlast,
	output logic [2:0]  m_tuser    // [2:0] status
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CW = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);

	logic          q_full, q_empty, push, pop;
	desc_t         push_desc, head;
	logic          pay_we, pay_wbank;
	logic [AW-1:0] pay_waddr;
	logic [7:0]    pay_wdata;

	fpr_front #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW),
		.CW          (CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc),
		.pay_we    (pay_we),
		.pay_wbank (pay_wbank),
		.pay_waddr (pay_waddr),
		.pay_wdata (pay_wdata)
	);

	fpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	fpr_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pay_we    (pay_we),
		.pay_wbank (pay_wbank),
		.pay_waddr (pay_waddr),
		.pay_wdata (pay_wdata),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

`ifndef NO_ASSERTIONS
	// Error results are always a single beat.
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> m_tlast)
		else $error("error result without last");

	// Within a frame the next beat follows at once with the next index.
	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && m_tdata[18:14] == $past(m_tdata[18:14]) + 5'd1))
		else $error("payload index did not advance");

	// A frame never starts in the cycle right after the previous one ended.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("beat sent without payload read cycle");

	// The front stalls only while the queue holds two frames.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready) |-> (q_full && !q_empty))
		else $error("input stalled with room in queue");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for framed_packet_receiver: byte stream in, payload beats out.
// Depends on fpr_pkg and the framed_packet_receiver RTL; predicts every output beat on its own
// and checks it while both sides idle and stall at random through several register settings.
module testbench;
	import fpr_pkg::*;

	localparam int MAX_PAY     = 32;
	localparam int STORE_DEPTH = MAX_PAY + FRAME_OVERHEAD;
	localparam int SETTLE      = 16;
	localparam int LIMIT       = 400000;

	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SEND_GAPS,
		FLOW_RECV_STALLS,
		FLOW_BOTH
	} flow_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  frame_type;
		logic [5:0]  plen;
		logic [4:0]  pidx;
		logic [7:0]  pbyte;
		logic        last;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_START;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;

	// Frame assembler copy and its registers.
	logic [7:0]  cur_start = START_RESET;
	logic [7:0]  cur_stop = STOP_RESET;
	logic        frame_open = 1'b0;
	int          frame_count = 0;
	logic [7:0]  frame_buf [0:STORE_DEPTH-1];

	logic [7:0]  rx_pending [$];
	beat_t       beats_due [$];
	int          send_gap_pct = 0;
	int          recv_stall_pct = 0;
	int          mismatches = 0;
	int          cycles = 0;

	framed_packet_receiver #(.MAX_PAYLOAD(MAX_PAY)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic beat_t closing_beat(status_t st, logic [7:0] typ);
		beat_t bt;
		bt.status     = st;
		bt.frame_type = typ;
		bt.plen       = 6'd0;
		bt.pidx       = 5'd0;
		bt.pbyte      = 8'd0;
		bt.last       = 1'b1;
		return bt;
	endfunction

	function automatic status_t frame_status();
		int         len;
		logic [7:0] sum;
		if (frame_count < FRAME_OVERHEAD)
			return ST_SHORT;
		len = frame_buf[1];
		if (len > MAX_PAY)
			return ST_LONG;
		if (frame_count != len + FRAME_OVERHEAD)
			return ST_MISMATCH;
		sum = frame_buf[1] ^ frame_buf[2];
		for (int i = 0; i < len; i++)
			sum = sum ^ frame_buf[PAYLOAD_OFS + i];
		if (sum != frame_buf[PAYLOAD_OFS + len])
			return ST_CHECKSUM;
		return ST_OK;
	endfunction

	task automatic assemble_byte(input logic [7:0] b);
		status_t st;
		int      len;
		beat_t   bt;
		if (!frame_open) begin
			if (b != cur_start)
				return;
			frame_open  = 1'b1;
			frame_count = 0;
		end
		if (frame_count >= STORE_DEPTH) begin
			frame_open  = 1'b0;
			frame_count = 0;
			beats_due.push_back(closing_beat(ST_OVERFLOW, 8'd0));
			return;
		end
		frame_buf[frame_count] = b;
		frame_count++;
		if (b != cur_stop)
			return;
		frame_open  = 1'b0;
		st          = frame_status();
		frame_count = 0;
		len         = frame_buf[1];
		if (st != ST_OK) begin
			beats_due.push_back(closing_beat(st, 8'd0));
		end else if (len == 0) begin
			beats_due.push_back(closing_beat(ST_OK, frame_buf[2]));
		end else begin
			for (int i = 0; i < len; i++) begin
				bt.status     = ST_OK;
				bt.frame_type = frame_buf[2];
				bt.plen       = 6'(len);
				bt.pidx       = 5'(i);
				bt.pbyte      = frame_buf[PAYLOAD_OFS + i];
				bt.last       = (i == len - 1);
				beats_due.push_back(bt);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				assemble_byte(s_tdata);
				void'(rx_pending.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (rx_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= rx_pending[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		beat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (beats_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat with nothing due: tuser %0d tdata %h tlast %0b",
							m_tuser, m_tdata, m_tlast);
				end else begin
					want = beats_due.pop_front();
					if (m_tuser !== want.status || m_tdata[7:0] !== want.frame_type ||
						m_tdata[13:8] !== want.plen || m_tdata[18:14] !== want.pidx ||
						m_tdata[26:19] !== want.pbyte || m_tdata[31:27] !== 5'd0 ||
						m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: want st %0d type %h len %0d idx %0d byte %h last %0b",
								want.status, want.frame_type, want.plen, want.pidx,
								want.pbyte, want.last);
							$display("  got st %0d type %h len %0d idx %0d byte %h pad %h last %0b",
								m_tuser, m_tdata[7:0], m_tdata[13:8], m_tdata[18:14],
								m_tdata[26:19], m_tdata[31:27], m_tlast);
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic [7:0] any_byte_but(logic [7:0] avoid);
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == avoid);
		return b;
	endfunction

	function automatic int pick_payload_len();
		int r;
		int n;
		r = $urandom_range(99);
		if (r < 80)
			n = $urandom_range(0, 5);
		else if (r < 95)
			n = $urandom_range(6, 31);
		else
			n = MAX_PAY;
		if (n == cur_stop)
			n = (n == 0) ? 1 : n - 1;
		return n;
	endfunction

	task automatic set_flow(input flow_t mode);
		case (mode)
			FLOW_FREE: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			FLOW_SEND_GAPS: begin
				send_gap_pct   = 87;
				recv_stall_pct = 0;
			end
			FLOW_RECV_STALLS: begin
				send_gap_pct   = 0;
				recv_stall_pct = 87;
			end
			default: begin
				send_gap_pct   = 25;
				recv_stall_pct = 25;
			end
		endcase
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_START)
			cur_start = value;
		else
			cur_stop = value;
		cfg_valid <= 1'b0;
	endtask

	// Holds off until every byte is taken and every beat has come out, then lets the
	// block settle, since a byte inside a frame produces nothing to wait for.
	task automatic wait_quiet();
		while (rx_pending.size() != 0 || s_tvalid || beats_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic queue_rx(input logic [7:0] b);
		rx_pending.push_back(b);
	endtask

	task automatic queue_frame(input int n_pay, input logic [7:0] len_field,
		input logic [7:0] kind, input bit bad_sum);
		logic [7:0] pay [0:STORE_DEPTH];
		logic [7:0] sum;
		logic [7:0] d;
		if (kind == cur_stop)
			kind = kind ^ 8'h80;
		sum = len_field ^ kind;
		for (int i = 0; i < n_pay; i++) begin
			pay[i] = any_byte_but(cur_stop);
			sum    = sum ^ pay[i];
		end
		// A checksum equal to the stop byte would close the frame early.
		if (sum == cur_stop) begin
			d = 8'd1;
			if (n_pay > 0) begin
				while ((pay[0] ^ d) == cur_stop)
					d++;
				pay[0] = pay[0] ^ d;
			end else begin
				while ((kind ^ d) == cur_stop)
					d++;
				kind = kind ^ d;
			end
			sum = sum ^ d;
		end
		if (bad_sum) begin
			do
				d = 8'($urandom_range(1, 255));
			while ((sum ^ d) == cur_stop);
			sum = sum ^ d;
		end
		queue_rx(cur_start);
		queue_rx(len_field);
		queue_rx(kind);
		for (int i = 0; i < n_pay; i++)
			queue_rx(pay[i]);
		queue_rx(sum);
		queue_rx(cur_stop);
	endtask

	task automatic queue_overflow();
		queue_rx(cur_start);
		repeat (STORE_DEPTH) queue_rx(any_byte_but(cur_stop));
	endtask

	task automatic queue_random_traffic(input int budget);
		int         sent;
		int         pick;
		int         n;
		int         d;
		int         k;
		logic [7:0] lf;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				n = pick_payload_len();
				queue_frame(n, 8'(n), 8'($urandom), 1'b0);
				sent += n + FRAME_OVERHEAD;
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 4)) queue_rx(any_byte_but(cur_start));
			end else if (pick < 76) begin
				n = pick_payload_len();
				queue_frame(n, 8'(n), 8'($urandom), 1'b1);
				sent += n + FRAME_OVERHEAD;
			end else if (pick < 82) begin
				n = $urandom_range(0, 8);
				d = $urandom_range(1, 3);
				if ($urandom_range(1)) begin
					lf = 8'(n + d);
				end else begin
					lf = 8'(n);
					n  = n + d;
				end
				if (lf == cur_stop)
					lf = lf + 8'd4;
				queue_frame(n, lf, 8'($urandom), 1'b0);
				sent += n + FRAME_OVERHEAD;
			end else if (pick < 86) begin
				do
					lf = 8'($urandom_range(MAX_PAY + 1, 255));
				while (lf == cur_stop);
				n = $urandom_range(0, 4);
				queue_frame(n, lf, 8'($urandom), 1'b0);
				sent += n + FRAME_OVERHEAD;
			end else if (pick < 91) begin
				k = $urandom_range(0, 3);
				queue_rx(cur_start);
				repeat (k) queue_rx(any_byte_but(cur_stop));
				queue_rx(cur_stop);
				sent += k + 2;
			end else if (pick < 94) begin
				queue_overflow();
				sent += STORE_DEPTH + 1;
			end else begin
				k = $urandom_range(1, 8);
				repeat (k) queue_rx(8'($urandom));
				sent += k;
			end
		end
	endtask

	initial begin
		logic [7:0] a;
		logic [7:0] b;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: idle noise, empty payload, short frame, bad checksum.
		set_flow(FLOW_FREE);
		queue_rx(8'h00);
		queue_rx(STOP_RESET);
		queue_frame(0, 8'd0, 8'hFF, 1'b0);
		queue_rx(START_RESET);
		queue_rx(8'hFF);
		queue_rx(STOP_RESET);
		queue_frame(1, 8'd1, 8'h00, 1'b1);
		wait_quiet();

		// Declared length off by one, then a frame left open across a register change.
		write_reg(CFG_START, 8'hFF);
		write_reg(CFG_STOP, 8'h00);
		set_flow(FLOW_SEND_GAPS);
		@(negedge clk);
		queue_frame(0, 8'd1, 8'h81, 1'b0);
		queue_rx(8'hFF);
		queue_rx(8'd2);
		queue_rx(8'h41);
		wait_quiet();
		write_reg(CFG_STOP, 8'hFF);
		write_reg(CFG_START, 8'h00);
		@(negedge clk);
		queue_rx(8'h10);
		queue_rx(8'h20);
		queue_rx(8'h73);
		queue_rx(8'hFF);
		wait_quiet();

		// The opening byte also closes the frame.
		write_reg(CFG_START, 8'h7E);
		write_reg(CFG_STOP, 8'h7E);
		set_flow(FLOW_RECV_STALLS);
		@(negedge clk);
		queue_rx(8'h7E);
		queue_rx(8'h7E);
		wait_quiet();

		for (int p = 0; p < 8; p++) begin
			if (p == 0) begin
				a = START_RESET;
				b = STOP_RESET;
			end else begin
				a = 8'($urandom);
				b = 8'($urandom);
				if (a == b)
					b = b ^ 8'h01;
			end
			write_reg(CFG_START, a);
			write_reg(CFG_STOP, b);
			set_flow(flow_t'(p % 4));
			@(negedge clk);
			if (p == 0) begin
				queue_frame(MAX_PAY, 8'(MAX_PAY), 8'($urandom), 1'b0);
				queue_overflow();
			end
			queue_random_traffic(38);
			wait_quiet();
		end

		mismatches += beats_due.size();
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

### files.f
src/fpr_pkg.sv
src/fpr_front.sv
src/fpr_queue.sv
src/fpr_back.sv
src/framed_packet_receiver.sv
tb/testbench.sv
